// File: sv/scba_pkg.sv
package scba_pkg;

  localparam int NUM_POOLS  = 5;
  localparam int QUEUE_SPAN = 64;
  localparam int POOL_W     = 3;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 7;

  localparam logic [POOL_W-1:0] PAGE_POOL = 3'd4;

  // Fixed block sizes of the four small pools
  localparam logic [15:0] BYTES_POOL0 = 16'd16;
  localparam logic [15:0] BYTES_POOL1 = 16'd32;
  localparam logic [15:0] BYTES_POOL2 = 16'd48;
  localparam logic [15:0] BYTES_POOL3 = 16'd64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED   = 2'd0;
  localparam logic [1:0] ST_NO_FIT      = 2'd1;
  localparam logic [1:0] ST_FREED       = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOCED = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_bytes;
    logic [2:0]  block_pool;
    logic [5:0]  block_slot;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] granted_pool;
    logic [5:0] granted_slot;
  } rsp_item_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_LOOKUP = 3'b010,
    PH_COMMIT = 3'b100
  } phase_t;

endpackage

// File: sv/scba_ram.sv
module scba_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/size_class_block_allocator_unit.sv
// Fixed-block allocator with five size-class pools (16, 32, 48, 64 bytes and a page).
// Requests arrive on req (req_valid/req_ready); each one gives exactly one response
// on rsp (rsp_valid/rsp_ready). An allocate takes the head of the free-slot queue of
// the smallest fitting pool that is not empty; a free of an allocated slot pushes it
// back to the tail of its pool's queue.
// Flow: a request passes two phases, lookup then commit, and its response is
// written to the response register at commit. The next request can be taken in
// the commit cycle, so a new request is accepted while the last one commits, as
// long as the response register is free. Lookup covers the registered read of the
// free-queue RAM, which holds the slot at the chosen pool's head.
// Reset puts every queue full with its slots ascending, clears all allocation marks
// and empties the response register. The queue RAM needs no clearing pass: a per-pool
// flag tells whether the head has gone once around; before that the head position is
// itself the stored slot.
// When the receiver stalls, the response register holds; a request in commit waits
// there and req_ready stays low until the response register can be written.
module size_class_block_allocator_unit
  import scba_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int PAGE_SLOTS = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int RAM_DEPTH = NUM_POOLS * QUEUE_SPAN;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [COUNT_W-1:0] STD_N  = COUNT_W'(SLOTS);
  localparam logic [COUNT_W-1:0] PAGE_N = COUNT_W'(PAGE_SLOTS);
  localparam logic [15:0]        PAGE_B = 16'(PAGE_BYTES);

  function automatic logic [COUNT_W-1:0] pool_n(input logic [POOL_W-1:0] p);
    return (p == PAGE_POOL) ? PAGE_N : STD_N;
  endfunction

  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                               input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] nxt;
    nxt = {1'b0, pos} + 1'b1;
    return (nxt >= n) ? '0 : nxt[POS_W-1:0];
  endfunction

  phase_t phase;
  phase_t phase_next;

  req_item_t in_q;

  logic [POS_W-1:0]      head  [NUM_POOLS];
  logic [POS_W-1:0]      tail  [NUM_POOLS];
  logic [COUNT_W-1:0]    count [NUM_POOLS];
  logic [QUEUE_SPAN-1:0] amap  [NUM_POOLS];
  logic [NUM_POOLS-1:0]  wrapped;

  // lookup results, registered for commit
  logic              c_op;
  logic              c_hit;
  logic [POOL_W-1:0] c_pool;
  logic [POS_W-1:0]  c_pos;
  logic              c_wrapped;
  logic [POS_W-1:0]  c_slot;

  logic [NUM_POOLS-1:0] fits;
  logic [15:0]          pool_bytes [NUM_POOLS];
  logic                 alloc_hit;
  logic [POOL_W-1:0]    alloc_pool;
  logic                 free_pool_ok;
  logic                 map_bit;
  logic                 count_below;
  logic                 free_hit;
  logic [POOL_W-1:0]    lk_pool;

  logic             out_free;
  logic             accept;
  logic             commit;
  logic [POS_W-1:0] alloc_slot;
  logic [POS_W-1:0] ram_rdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [RAM_AW-1:0] ram_waddr;
  logic             ram_we;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (phase == PH_IDLE) || ((phase == PH_COMMIT) && out_free);
  assign accept    = req_valid && req_ready;
  assign commit    = (phase == PH_COMMIT) && out_free;

  assign pool_bytes[0] = BYTES_POOL0;
  assign pool_bytes[1] = BYTES_POOL1;
  assign pool_bytes[2] = BYTES_POOL2;
  assign pool_bytes[3] = BYTES_POOL3;
  assign pool_bytes[4] = PAGE_B;

  // Lookup: pool choice for allocate, validity check for free
  always_comb begin
    alloc_hit  = 1'b0;
    alloc_pool = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      fits[p] = (in_q.request_bytes <= pool_bytes[p]) && (count[p] != '0);
    end
    for (int p = NUM_POOLS - 1; p >= 0; p--) begin
      if (fits[p]) begin
        alloc_hit  = 1'b1;
        alloc_pool = POOL_W'(p);
      end
    end

    free_pool_ok = (in_q.block_pool < POOL_W'(NUM_POOLS)) &&
                   ({1'b0, in_q.block_slot} < pool_n(in_q.block_pool));
    map_bit     = 1'b0;
    count_below = 1'b0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (in_q.block_pool == POOL_W'(p)) begin
        map_bit     = amap[p][in_q.block_slot];
        count_below = count[p] < pool_n(POOL_W'(p));
      end
    end
    free_hit = free_pool_ok && map_bit && count_below;

    lk_pool = (in_q.opcode == OP_ALLOC) ? alloc_pool : '0;
  end

  assign ram_raddr = RAM_AW'({lk_pool, head[lk_pool]});

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:   if (accept) phase_next = PH_LOOKUP;
      PH_LOOKUP: phase_next = PH_COMMIT;
      PH_COMMIT: begin
        if (commit) phase_next = accept ? PH_LOOKUP : PH_IDLE;
      end
      default:   phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= req;
    end
    if (phase == PH_LOOKUP) begin
      c_op      <= in_q.opcode;
      c_hit     <= (in_q.opcode == OP_ALLOC) ? alloc_hit : free_hit;
      c_pool    <= (in_q.opcode == OP_ALLOC) ? alloc_pool : in_q.block_pool;
      c_pos     <= head[lk_pool];
      c_wrapped <= wrapped[lk_pool];
      c_slot    <= in_q.block_slot;
    end
  end

  // Before the head's first wrap the queue entry equals its position
  assign alloc_slot = c_wrapped ? ram_rdata : c_pos;

  assign ram_we    = commit && (c_op == OP_FREE) && c_hit;
  assign ram_waddr = RAM_AW'({c_pool, tail[c_pool]});

  scba_ram #(
    .WIDTH (POS_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (c_slot),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        head[p]  <= '0;
        tail[p]  <= '0;
        count[p] <= pool_n(POOL_W'(p));
        amap[p]  <= '0;
      end
      wrapped <= '0;
    end else if (commit && c_hit) begin
      if (c_op == OP_ALLOC) begin
        head[c_pool]           <= advance(c_pos, pool_n(c_pool));
        count[c_pool]          <= count[c_pool] - 1'b1;
        amap[c_pool][alloc_slot] <= 1'b1;
        if (advance(c_pos, pool_n(c_pool)) == '0) begin
          wrapped[c_pool] <= 1'b1;
        end
      end else begin
        tail[c_pool]         <= advance(tail[c_pool], pool_n(c_pool));
        count[c_pool]        <= count[c_pool] + 1'b1;
        amap[c_pool][c_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.granted_pool <= '0;
      rsp.granted_slot <= '0;
      if (c_op == OP_ALLOC) begin
        if (c_hit) begin
          rsp.status       <= ST_ALLOCATED;
          rsp.granted_pool <= c_pool;
          rsp.granted_slot <= alloc_slot;
        end else begin
          rsp.status <= ST_NO_FIT;
        end
      end else begin
        rsp.status <= c_hit ? ST_FREED : ST_NOT_ALLOCED;
      end
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import scba_pkg::*;
();

  localparam int SLOTS      = 64;
  localparam int PAGE_SLOTS = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int RANDOM_REQUESTS = 1750;
  localparam int LONG_HOLD = 300;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  size_class_block_allocator_unit #(
    .SLOTS     (SLOTS),
    .PAGE_SLOTS(PAGE_SLOTS),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow allocator state
  logic [5:0]  pool_ring  [NUM_POOLS][QUEUE_SPAN];
  logic [5:0]  pool_head  [NUM_POOLS];
  logic [5:0]  pool_tail  [NUM_POOLS];
  logic [6:0]  pool_free  [NUM_POOLS];
  logic [63:0] pool_taken [NUM_POOLS];

  req_item_t pending_reqs[$];
  rsp_item_t expected_rsps[$];

  logic req_took = 1'b0;
  logic rsp_took = 1'b0;
  int   errors = 0;
  int   n_grant = 0, n_nofit = 0, n_freed = 0, n_reject = 0, n_exhausted = 0;
  int   holds_wanted = 0;

  function automatic int slots_of(input int p);
    return (p == PAGE_POOL) ? PAGE_SLOTS : SLOTS;
  endfunction

  function automatic int block_bytes(input int p);
    case (p)
      0:       return BYTES_POOL0;
      1:       return BYTES_POOL1;
      2:       return BYTES_POOL2;
      3:       return BYTES_POOL3;
      default: return PAGE_BYTES;
    endcase
  endfunction

  function automatic logic [5:0] step_pos(input logic [5:0] pos, input int n);
    int nxt;
    nxt = int'(pos) + 1;
    return (nxt >= n) ? 6'd0 : nxt[5:0];
  endfunction

  function automatic void pools_reset();
    for (int p = 0; p < NUM_POOLS; p++) begin
      for (int i = 0; i < QUEUE_SPAN; i++)
        pool_ring[p][i] = (i < slots_of(p)) ? i[5:0] : 6'd0;
      pool_head[p]  = '0;
      pool_tail[p]  = '0;
      pool_free[p]  = 7'(slots_of(p));
      pool_taken[p] = '0;
    end
  endfunction

  function automatic rsp_item_t alloc_or_free(input req_item_t r);
    rsp_item_t  o;
    logic       found;
    logic [5:0] s;
    int         bp;
    o = '0;
    o.status = ST_NO_FIT;
    if (r.opcode == OP_ALLOC) begin
      found = 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        if (!found && int'(r.request_bytes) <= block_bytes(p) && pool_free[p] != 0) begin
          found = 1'b1;
          s = pool_ring[p][pool_head[p]];
          pool_head[p] = step_pos(pool_head[p], slots_of(p));
          pool_free[p] = pool_free[p] - 7'd1;
          pool_taken[p][s] = 1'b1;
          o.status = ST_ALLOCATED;
          o.granted_pool = p[2:0];
          o.granted_slot = s;
        end
      end
      // no fit although the size was servable: every fitting pool ran dry
      if (!found && int'(r.request_bytes) <= PAGE_BYTES)
        n_exhausted++;
    end else begin
      o.status = ST_NOT_ALLOCED;
      bp = int'(r.block_pool);
      if (bp < NUM_POOLS && int'(r.block_slot) < slots_of(bp)) begin
        if (pool_taken[bp][r.block_slot] && int'(pool_free[bp]) < slots_of(bp)) begin
          pool_taken[bp][r.block_slot] = 1'b0;
          pool_ring[bp][pool_tail[bp]] = r.block_slot;
          pool_tail[bp] = step_pos(pool_tail[bp], slots_of(bp));
          pool_free[bp] = pool_free[bp] + 7'd1;
          o.status = ST_FREED;
        end
      end
    end
    return o;
  endfunction

  // Rising edge: check responses, then record accepted requests
  always @(posedge clk) begin : observe
    rsp_item_t want;
    if (rst) begin
      pools_reset();
      expected_rsps.delete();
      req_took <= 1'b0;
      rsp_took <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with nothing outstanding: status %0d pool %0d slot %0d",
                   $time, rsp.status, rsp.granted_pool, rsp.granted_slot);
          errors++;
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            errors++;
          end
          if (rsp.granted_pool !== want.granted_pool) begin
            $display("%0t: granted_pool expected %0d actual %0d",
                     $time, want.granted_pool, rsp.granted_pool);
            errors++;
          end
          if (rsp.granted_slot !== want.granted_slot) begin
            $display("%0t: granted_slot expected %0d actual %0d",
                     $time, want.granted_slot, rsp.granted_slot);
            errors++;
          end
          case (want.status)
            ST_ALLOCATED: n_grant++;
            ST_NO_FIT:    n_nofit++;
            ST_FREED:     n_freed++;
            default:      n_reject++;
          endcase
        end
      end
      if (req_valid && req_ready)
        expected_rsps.insert(expected_rsps.size(), alloc_or_free(req));
      req_took <= req_valid && req_ready;
      rsp_took <= rsp_valid && rsp_ready;
    end
  end

  // Request driver
  int send_wait = 0;
  bit send_tight = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (req_took) begin
        if ($urandom_range(0, 47) == 0)
          send_tight = !send_tight;
        send_wait = send_tight ? 0 : $urandom_range(0, 13);
      end
      if (send_wait > 0) begin
        send_wait--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req       <= pending_reqs[0];
        pending_reqs.delete(0);
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response receiver
  int hold_left = 0;
  int holds_served = 0;
  int recv_wait = 0;
  bit recv_tight = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (holds_served < holds_wanted) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (rsp_took) begin
        if ($urandom_range(0, 47) == 0)
          recv_tight = !recv_tight;
        recv_wait = recv_tight ? 0 : $urandom_range(0, 13);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic req_item_t alloc_req(input int nbytes);
    req_item_t r;
    r.opcode        = OP_ALLOC;
    r.request_bytes = nbytes[15:0];
    r.block_pool    = 3'($urandom_range(0, 7));
    r.block_slot    = 6'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic req_item_t free_req(input int p, input int s);
    req_item_t r;
    r.opcode        = OP_FREE;
    r.request_bytes = 16'($urandom_range(0, 65535));
    r.block_pool    = p[2:0];
    r.block_slot    = s[5:0];
    return r;
  endfunction

  function automatic int draw_bytes();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return $urandom_range(0, 16);
      4, 5:       return $urandom_range(17, 32);
      6, 7:       return $urandom_range(33, 48);
      8, 9:       return $urandom_range(49, 64);
      10, 11:     return $urandom_range(65, PAGE_BYTES);
      12: begin
        case ($urandom_range(0, 5))
          0:       return 16 + $urandom_range(0, 1);
          1:       return 32 + $urandom_range(0, 1);
          2:       return 48 + $urandom_range(0, 1);
          3:       return 64 + $urandom_range(0, 1);
          4:       return PAGE_BYTES + $urandom_range(0, 1);
          default: return 65535;
        endcase
      end
      13:         return $urandom_range(PAGE_BYTES + 1, 65535);
      default:    return $urandom_range(0, 65535);
    endcase
  endfunction

  // Find some currently allocated block, starting from random points
  function automatic bit pick_taken(output int p, output int s);
    int p0, s0;
    p0 = $urandom_range(0, NUM_POOLS - 1);
    s0 = $urandom_range(0, 63);
    for (int i = 0; i < NUM_POOLS; i++) begin
      p = (p0 + i) % NUM_POOLS;
      if (pool_taken[p] != 0) begin
        for (int j = 0; j < 64; j++) begin
          s = (s0 + j) % 64;
          if (pool_taken[p][s])
            return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic push_req(input req_item_t r);
    while (pending_reqs.size() >= 3)
      @(posedge clk);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int   sent, phase_len, phase_no, p, s;
    mix_t mix;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // boundaries of every size class
    push_req(alloc_req(0));
    push_req(alloc_req(16));
    push_req(alloc_req(17));
    push_req(alloc_req(32));
    push_req(alloc_req(33));
    push_req(alloc_req(48));
    push_req(alloc_req(49));
    push_req(alloc_req(64));
    push_req(alloc_req(65));
    push_req(alloc_req(PAGE_BYTES));
    push_req(alloc_req(PAGE_BYTES + 1));
    push_req(alloc_req(65535));
    // good free, double free, never-allocated slot, bad pool numbers
    push_req(free_req(0, 0));
    push_req(free_req(0, 0));
    push_req(free_req(0, 63));
    push_req(free_req(5, 1));
    push_req(free_req(6, 0));
    push_req(free_req(7, 63));
    push_req(free_req(PAGE_POOL, 1));
    push_req(free_req(3, 0));
    push_req(free_req(PAGE_POOL, 0));
    push_req(alloc_req(1));
    push_req(alloc_req(PAGE_BYTES));
    wait_quiet();

    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_REQUESTS) begin
      mix = (phase_no % 3 == 0) ? MIX_FILL : (phase_no % 3 == 1) ? MIX_DRAIN : MIX_EVEN;
      phase_len = $urandom_range(150, 350);
      for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
        // long receiver stall mid-phase while requests keep coming
        if (k == 40 && (phase_no == 0 || phase_no == 4))
          holds_wanted++;
        if ((mix == MIX_FILL && $urandom_range(0, 99) < 85) ||
            (mix == MIX_DRAIN && $urandom_range(0, 99) < 15) ||
            (mix == MIX_EVEN && $urandom_range(0, 1) == 0)) begin
          push_req(alloc_req(draw_bytes()));
        end else if ($urandom_range(0, 4) != 0 && pick_taken(p, s)) begin
          push_req(free_req(p, s));
        end else begin
          push_req(free_req($urandom_range(0, 7), $urandom_range(0, 63)));
        end
        sent++;
      end
      if (mix == MIX_DRAIN)
        wait_quiet();
      phase_no++;
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    $display("covered %0d grants, %0d no-fit answers (%0d with all fitting pools empty)",
             n_grant, n_nofit, n_exhausted);
    $display("and %0d successful frees, %0d rejected frees, %0d long receiver stalls",
             n_freed, n_reject, holds_served);
    if (errors == 0)
      $display("size_class_block_allocator_unit verification clean");
    else
      $display("size_class_block_allocator_unit verification failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("size_class_block_allocator_unit verification failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/scba_pkg.sv
sv/scba_ram.sv
sv/size_class_block_allocator_unit.sv
verif/tb_top.sv
